>>> src/wrt_pkg.sv
// Package for the wildcard record table: types, codes and text helpers.
`default_nettype none

package wrt_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int CHARS_DEF   = 8;
  localparam int TEXT_W      = 64;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 6;

  typedef enum logic [2:0] {
    MODE_PUSH      = 3'd0,
    MODE_FIND      = 3'd1,
    MODE_DEL_INDEX = 3'd2,
    MODE_DEL_MATCH = 3'd3,
    MODE_LIST      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t               mode;
    logic [TEXT_W-1:0]   name_text;
    logic [TEXT_W-1:0]   family_text;
    logic [TEXT_W-1:0]   phone_text;
    logic [INDEX_W-1:0]  slot_index;
  } in_req_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [TEXT_W-1:0]   out_name;
    logic [TEXT_W-1:0]   out_family;
    logic [TEXT_W-1:0]   out_phone;
    logic [COUNT_W-1:0]  match_count;
    logic                last;
  } out_req_t;

  // Three text fields of one record, as held in the store.
  typedef struct packed {
    logic [TEXT_W-1:0] name;
    logic [TEXT_W-1:0] family;
    logic [TEXT_W-1:0] phone;
  } record_t;

  // Keep the first chars bytes and cut at the first zero byte.
  function automatic logic [TEXT_W-1:0] norm_text(logic [TEXT_W-1:0] v, int chars);
    logic [TEXT_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int k = 0; k < TEXT_W / 8; k++) begin
      if (v[8*k +: 8] == 8'h00 || k >= chars) alive = 1'b0;
      if (alive) r[8*k +: 8] = v[8*k +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/wrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/wrt_match.sv
// Shared compare unit: wildcard pattern match or full-record test.
`default_nettype none

module wrt_match
  import wrt_pkg::*;
(
  input  wire record_t pattern,
  input  wire record_t rec,
  input  wire logic    list_mode,
  output logic         hit
);

  logic name_ok;
  logic family_ok;
  logic phone_ok;

  // Empty pattern fields act as wildcards.
  always_comb begin
    name_ok   = (pattern.name   == '0) || (rec.name   == pattern.name);
    family_ok = (pattern.family == '0) || (rec.family == pattern.family);
    phone_ok  = (pattern.phone  == '0) || (rec.phone  == pattern.phone);
    if (list_mode) begin
      hit = (rec.name != '0) && (rec.family != '0) && (rec.phone != '0);
    end else begin
      hit = name_ok && family_ok && phone_ok;
    end
  end

endmodule

`default_nettype wire

>>> src/wildcard_record_table.sv
// Top level of the wildcard record table: sequencer, store and result register.
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------
// in_      | input     | in_valid/in_stall  | in_req_t: mode, texts, slot
// out_     | output    | out_valid/out_stall| out_req_t: kind, index, texts
//
// Find, delete by pattern and list take the request, step through every slot
// in the shared compare unit (the store RAM streams one record a cycle while
// no hit waits on a stalled result), then give the count result. Push and
// delete by index give one result; unknown modes are taken with no result.
// Reset clears the slot valid bits at once: no clearing pass is needed.
// A stall on out_ holds the scan on a hitting slot until the result drains;
// in_stall is high from the cycle after a request is taken until it finishes.

module wildcard_record_table
  import wrt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int CHARS   = CHARS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int REC_W = $bits(record_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0]   wslot_r, wslot_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Request and result payload
  mode_t              mode_r;
  record_t            pat_r;
  logic [INDEX_W-1:0] ix_r;
  out_req_t           out_data_r, out_data_nxt;

  logic    accept;
  logic    can_emit;
  logic    emit;
  logic    wr_en;
  record_t rd_rec;
  record_t rec;
  logic    hit;
  logic    is_scan_mode;
  logic    is_op_mode;
  logic    ix_bad;

  assign accept   = in_valid && !in_stall;
  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign is_scan_mode = (in_data.mode == MODE_FIND) || (in_data.mode == MODE_DEL_MATCH) ||
                        (in_data.mode == MODE_LIST);
  assign is_op_mode   = (in_data.mode == MODE_PUSH) || (in_data.mode == MODE_DEL_INDEX);
  assign ix_bad       = (ix_r >= INDEX_W'(ENTRIES));

  // Record store: read address is the next slot index, so read data matches the compare slot.
  wrt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wslot_r),
    .wr_data (pat_r),
    .rd_addr (idx_nxt),
    .rd_data (rd_rec)
  );

  // A slot that was never written or was blanked reads as empty.
  assign rec = valid_r[idx_r] ? rd_rec : '0;

  wrt_match u_match (
    .pattern   (pat_r),
    .rec       (rec),
    .list_mode (mode_r == MODE_LIST),
    .hit       (hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_scan_mode) state_nxt = ST_SCAN;
        else if (accept && is_op_mode) state_nxt = ST_OP;
      end
      ST_OP: begin
        if (can_emit) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!(hit && !can_emit) && idx_r == LAST_IDX) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (can_emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    wslot_nxt    = wslot_r;
    valid_nxt    = valid_r;
    wr_en        = 1'b0;
    emit         = 1'b0;
    out_data_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt   = '0;
        count_nxt = '0;
      end
      ST_OP: begin
        if (can_emit) begin
          case (mode_r)
            MODE_PUSH: begin
              // Write the record, mark it live and advance the ring pointer.
              wr_en            = 1'b1;
              valid_nxt[wslot_r] = 1'b1;
              wslot_nxt        = (wslot_r == LAST_IDX) ? '0 : wslot_r + 1'b1;
              emit             = 1'b1;
              out_data_nxt.kind        = KIND_DONE;
              out_data_nxt.entry_index = INDEX_W'(wslot_nxt);
              out_data_nxt.last        = 1'b1;
            end
            MODE_DEL_INDEX: begin
              emit = 1'b1;
              out_data_nxt.entry_index = ix_r;
              out_data_nxt.last        = 1'b1;
              if (ix_bad) begin
                out_data_nxt.kind = KIND_ERROR;
              end else begin
                valid_nxt[ix_r[IDX_W-1:0]] = 1'b0;
                out_data_nxt.kind          = KIND_DONE;
                out_data_nxt.match_count   = COUNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Hold on a hit while the result register is still full.
        if (!(hit && !can_emit)) begin
          if (hit) begin
            emit      = 1'b1;
            count_nxt = count_r + 1'b1;
            out_data_nxt.kind        = KIND_ENTRY;
            out_data_nxt.entry_index = INDEX_W'(idx_r);
            out_data_nxt.out_name    = rec.name;
            out_data_nxt.out_family  = rec.family;
            out_data_nxt.out_phone   = rec.phone;
            if (mode_r == MODE_DEL_MATCH) valid_nxt[idx_r] = 1'b0;
          end
          if (idx_r != LAST_IDX) idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          emit = 1'b1;
          out_data_nxt.kind        = KIND_DONE;
          out_data_nxt.match_count = count_r;
          out_data_nxt.last        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register: load on emit, drop once taken.
  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      wslot_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      wslot_r     <= wslot_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r       <= in_data.mode;
      pat_r.name   <= norm_text(in_data.name_text, CHARS);
      pat_r.family <= norm_text(in_data.family_text, CHARS);
      pat_r.phone  <= norm_text(in_data.phone_text, CHARS);
      ix_r         <= in_data.slot_index;
    end
    if (emit) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
